@@ hw/rtl/m3i_pkg.sv @@
package m3i_pkg;

   // fixed formats of the result fields
   localparam int OUT_FRAC   = 16;
   localparam int INV_WIDTH  = 32;
   // quotient bits kept before saturation: enough to tell 2^31 and above
   localparam int QUOT_BITS  = INV_WIDTH + 1;
   localparam int FRONT_DEPTH = 5;
   localparam int QUEUE_DEPTH = 2;

endpackage

@@ hw/rtl/m3i_front.sv @@
module m3i_front #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [9*ELEM_WIDTH-1:0]       in_elem,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [9*(2*ELEM_WIDTH+1)-1:0] out_cof,
   output logic [3*ELEM_WIDTH:0]         out_det,
   output logic                          out_singular
);
   import m3i_pkg::*;

   localparam int E  = ELEM_WIDTH;
   localparam int PW = 2 * E;
   localparam int CW = 2 * E + 1;
   localparam int DW = 3 * E + 1;
   localparam int NS = FRONT_DEPTH;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   logic signed [E-1:0]  m1_ff   [3][3];
   logic signed [PW-1:0] pa_ff   [9];
   logic signed [PW-1:0] pb_ff   [9];
   logic signed [E-1:0]  col2_ff [3];
   logic signed [CW-1:0] cof3_ff [9];
   logic signed [E-1:0]  col3_ff [3];
   logic signed [DW-1:0] dp_ff   [3];
   logic signed [CW-1:0] cof4_ff [9];
   logic signed [CW-1:0] cof5_ff [9];
   logic signed [DW-1:0] det5_ff;
   logic                 sing5_ff;
   logic signed [DW+1:0] det_sum;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               m1_ff[r][c] <= in_elem[(c*3+r)*E +: E];
            end
         end
      end
   end

   for (genvar gi = 0; gi < 3; gi++) begin : g_row
      for (genvar gj = 0; gj < 3; gj++) begin : g_col
         localparam int I1 = (gi + 1) % 3;
         localparam int I2 = (gi + 2) % 3;
         localparam int J1 = (gj + 1) % 3;
         localparam int J2 = (gj + 2) % 3;
         always_ff @(posedge clock) begin
            if (en[1]) begin
               pa_ff[gi*3+gj] <= m1_ff[I1][J1] * m1_ff[I2][J2];
               pb_ff[gi*3+gj] <= m1_ff[I1][J2] * m1_ff[I2][J1];
            end
         end
      end
   end

   assign det_sum = (DW+2)'(dp_ff[0]) + (DW+2)'(dp_ff[1]) + (DW+2)'(dp_ff[2]);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int r = 0; r < 3; r++) begin
            col2_ff[r] <= m1_ff[r][0];
         end
      end
      if (en[2]) begin
         for (int k = 0; k < 9; k++) begin
            cof3_ff[k] <= CW'(pa_ff[k]) - CW'(pb_ff[k]);
         end
         col3_ff <= col2_ff;
      end
      if (en[3]) begin
         for (int r = 0; r < 3; r++) begin
            dp_ff[r] <= col3_ff[r] * cof3_ff[r*3];
         end
         cof4_ff <= cof3_ff;
      end
      if (en[4]) begin
         // exact: the determinant always fits DW bits
         det5_ff  <= det_sum[DW-1:0];
         sing5_ff <= (det_sum == '0);
         cof5_ff  <= cof4_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         out_cof[k*CW +: CW] = cof5_ff[k];
      end
   end

   assign out_valid    = v_ff[NS-1];
   assign out_det      = det5_ff;
   assign out_singular = sing5_ff;

endmodule

@@ hw/rtl/m3i_queue.sv @@
module m3i_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import m3i_pkg::*;

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [1:0]       cnt_ff;
   logic             wptr_ff;
   logic             rptr_ff;
   logic             push;
   logic             pop;

   assign push_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop) begin
            rptr_ff <= !rptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_ptr_match : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'(QUEUE_DEPTH)) |-> (wptr_ff == rptr_ff))
      else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/m3i_back.sv @@
module m3i_back #(
   parameter int ELEM_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [9*(2*ELEM_WIDTH+1)-1:0] in_cof,
   input  logic [3*ELEM_WIDTH:0]         in_det,
   input  logic                          in_singular,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [9*m3i_pkg::INV_WIDTH-1:0] out_inv,
   output logic [3*ELEM_WIDTH:0]         out_det,
   output logic                          out_singular
);
   import m3i_pkg::*;

   localparam int E    = ELEM_WIDTH;
   localparam int CW   = 2 * E + 1;
   localparam int DW   = 3 * E + 1;
   localparam int AW   = 2 * E;
   localparam int MW   = 3 * E;
   localparam int QB   = QUOT_BITS;
   localparam int SH   = FRAC_BITS + OUT_FRAC;
   localparam int NUMW = AW + SH;
   localparam int NW0  = (NUMW > MW) ? NUMW : MW;
   localparam int NW   = ((NW0 > QB) ? NW0 : QB) + 1;
   localparam int HW   = NW - QB;
   localparam int CMPW = (HW > MW) ? HW : MW;
   localparam int NS   = QB + 2;
   localparam logic [QB-1:0] NEG_LIMIT = QB'(1) << (INV_WIDTH - 1);
   localparam logic [QB-1:0] POS_LIMIT = NEG_LIMIT - QB'(1);

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   logic [MW-1:0]  rem_ff  [QB+1][9];
   logic [QB-1:0]  low_ff  [QB+1][9];
   logic [QB-1:0]  q_ff    [QB+1][9];
   logic           neg_ff  [QB+1][9];
   logic           ovf_ff  [QB+1][9];
   logic [MW-1:0]  den_ff  [QB+1];
   logic [DW-1:0]  det_ff  [QB+1];
   logic           sing_ff [QB+1];

   logic [INV_WIDTH-1:0] inv_ff [9];
   logic [DW-1:0]        det_o_ff;
   logic                 sing_o_ff;

   logic signed [DW-1:0] det_s;
   logic signed [DW-1:0] det_abs;
   logic [MW-1:0]        den_mag;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   assign det_s   = in_det;
   assign det_abs = det_s[DW-1] ? -det_s : det_s;
   assign den_mag = det_abs[MW-1:0];

   // setup: magnitudes, rounding offset of half the divisor, overflow of the top part
   for (genvar gk = 0; gk < 9; gk++) begin : g_lane
      logic signed [CW-1:0] adj_s;
      logic signed [CW-1:0] adj_abs;
      logic [NUMW-1:0]      num;
      logic [NW-1:0]        dividend;
      logic [CMPW-1:0]      hi_ext;

      assign adj_s    = in_cof[gk*CW +: CW];
      assign adj_abs  = adj_s[CW-1] ? -adj_s : adj_s;
      assign num      = {adj_abs[AW-1:0], SH'(0)};
      assign dividend = NW'(num) + NW'(den_mag >> 1);
      assign hi_ext   = CMPW'(dividend[NW-1:QB]);

      always_ff @(posedge clock) begin
         if (en[0]) begin
            rem_ff[0][gk] <= hi_ext[MW-1:0];
            low_ff[0][gk] <= dividend[QB-1:0];
            q_ff[0][gk]   <= '0;
            neg_ff[0][gk] <= adj_s[CW-1] ^ det_s[DW-1];
            ovf_ff[0][gk] <= (hi_ext >= CMPW'(den_mag));
         end
      end

      // one restoring step per stage, quotient msb first
      for (genvar gt = 1; gt <= QB; gt++) begin : g_step
         logic [MW:0] trial;
         logic [MW:0] diff;
         logic        ge;

         assign trial = {rem_ff[gt-1][gk], low_ff[gt-1][gk][QB-1]};
         assign diff  = trial - {1'b0, den_ff[gt-1]};
         assign ge    = (trial >= {1'b0, den_ff[gt-1]});

         always_ff @(posedge clock) begin
            if (en[gt]) begin
               rem_ff[gt][gk] <= ge ? diff[MW-1:0] : trial[MW-1:0];
               low_ff[gt][gk] <= low_ff[gt-1][gk] << 1;
               q_ff[gt][gk]   <= {q_ff[gt-1][gk][QB-2:0], ge};
               neg_ff[gt][gk] <= neg_ff[gt-1][gk];
               ovf_ff[gt][gk] <= ovf_ff[gt-1][gk];
            end
         end
      end

      logic [QB-1:0] q_fin;
      logic [QB-1:0] q_neg;
      logic [INV_WIDTH-1:0] res;

      assign q_fin = q_ff[QB][gk];
      assign q_neg = (ovf_ff[QB][gk] || q_fin > NEG_LIMIT) ? NEG_LIMIT : q_fin;

      always_comb begin
         if (sing_ff[QB]) begin
            res = '0;
         end else if (neg_ff[QB][gk]) begin
            res = INV_WIDTH'(-q_neg);
         end else if (ovf_ff[QB][gk] || q_fin > POS_LIMIT) begin
            res = POS_LIMIT[INV_WIDTH-1:0];
         end else begin
            res = q_fin[INV_WIDTH-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en[NS-1]) begin
            inv_ff[gk] <= res;
         end
      end

      assign out_inv[gk*INV_WIDTH +: INV_WIDTH] = inv_ff[gk];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         den_ff[0]  <= den_mag;
         det_ff[0]  <= in_det;
         sing_ff[0] <= in_singular;
      end
      for (int t = 1; t <= QB; t++) begin
         if (en[t]) begin
            den_ff[t]  <= den_ff[t-1];
            det_ff[t]  <= det_ff[t-1];
            sing_ff[t] <= sing_ff[t-1];
         end
      end
      if (en[NS-1]) begin
         det_o_ff  <= det_ff[QB];
         sing_o_ff <= sing_ff[QB];
      end
   end

   assign out_valid    = v_ff[NS-1];
   assign out_det      = det_o_ff;
   assign out_singular = sing_o_ff;

   a_sing_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_singular) |-> (out_inv == '0 && out_det == '0))
      else $error("singular beat with nonzero payload");

   a_nonsing_det : assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_singular) |-> (out_det != '0))
      else $error("regular beat with zero determinant");

endmodule

@@ hw/rtl/matrix3x3_inverse.sv @@
// 3x3 matrix inverse by the adjugate. Each req beat carries nine signed elements
// (ELEM_WIDTH bits, FRAC_BITS fraction bits); each rsp beat returns the exact
// determinant (3*FRAC_BITS fraction bits), nine inverse elements in saturated
// Q16.16 rounded to nearest with ties away from zero, and a singular flag in
// tuser that zeroes the inverse. One matrix is taken per cycle while rsp_tready
// does not hold the pipeline. A matrix passes the cofactor and determinant
// pipeline, the queue between the parts, and the divider, which has one restoring
// quotient bit per stage for 33 quotient bits plus a setup and a saturation stage.
module matrix3x3_inverse #(
   parameter int ELEM_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_r0c0, a_r1c0, a_r2c0, a_r0c1, a_r1c1, a_r2c1, a_r0c2, a_r1c2, a_r2c2
   input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // inv_r0c0, inv_r1c0, inv_r2c0, inv_r0c1, inv_r1c1, inv_r2c1,
   // inv_r0c2, inv_r1c2, inv_r2c2, det_value
   output logic [((9*m3i_pkg::INV_WIDTH+3*ELEM_WIDTH+1+7)/8)*8-1:0] rsp_tdata,
   // singular
   output logic [0:0] rsp_tuser
);
   import m3i_pkg::*;

   localparam int CW    = 2 * ELEM_WIDTH + 1;
   localparam int DW    = 3 * ELEM_WIDTH + 1;
   localparam int QW    = 9 * CW + DW + 1;
   localparam int OUTDW = ((9*INV_WIDTH + DW + 7) / 8) * 8;

   logic            f_valid;
   logic            f_ready;
   logic [9*CW-1:0] f_cof;
   logic [DW-1:0]   f_det;
   logic            f_sing;
   logic [QW-1:0]   q_in;
   logic [QW-1:0]   q_out;
   logic            b_valid;
   logic            b_ready;
   logic [9*INV_WIDTH-1:0] inv;
   logic [DW-1:0]   det;
   logic            sing;

   m3i_front #(.ELEM_WIDTH(ELEM_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_elem      (req_tdata[9*ELEM_WIDTH-1:0]),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_cof      (f_cof),
      .out_det      (f_det),
      .out_singular (f_sing)
   );

   assign q_in = {f_sing, f_det, f_cof};

   m3i_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (q_out)
   );

   m3i_back #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (b_valid),
      .in_ready     (b_ready),
      .in_cof       (q_out[9*CW-1:0]),
      .in_det       (q_out[9*CW +: DW]),
      .in_singular  (q_out[QW-1]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_inv      (inv),
      .out_det      (det),
      .out_singular (sing)
   );

   assign rsp_tdata = OUTDW'({det, inv});
   assign rsp_tuser = sing;

endmodule

@@ tb/m3i_checker.sv @@
`timescale 1ns / 1ps
module m3i_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [343:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [48:0]      det;
      logic [8:0][31:0] inv;
      logic             singular;
   } inverse_type;

   inverse_type expected_q[$];

   function automatic logic [31:0] scaled_quot(longint adj, longint det);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      bit neg;
      neg = (adj < 0) != (det < 0);
      num = (adj < 0 ? -adj : adj);
      num = num << 24;
      den = (det < 0 ? -det : det);
      q = (num + den / 2) / den;
      if (neg) begin
         if (q > 128'h8000_0000) q = 128'h8000_0000;
         return -q[31:0];
      end
      if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
      return q[31:0];
   endfunction

   function automatic inverse_type predict_inverse(logic [143:0] d);
      longint m [3][3];
      longint cof [3][3];
      longint det;
      inverse_type res;
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++)
            m[r][c] = longint'($signed(d[(c*3+r)*16 +: 16]));
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                      - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
      det = m[0][0]*cof[0][0] + m[1][0]*cof[1][0] + m[2][0]*cof[2][0];
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++)
            res.inv[c*3+r] = (det == 0) ? 32'd0 : scaled_quot(cof[c][r], det);
      res.det = det[48:0];
      res.singular = (det == 0);
      return res;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      inverse_type want;
      inverse_type got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_q.push_back(predict_inverse(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            for (int k = 0; k < 9; k++) got.inv[k] = rsp_tdata[k*32 +: 32];
            got.det = rsp_tdata[288 +: 49];
            got.singular = rsp_tuser[0];
            if (expected_q.size() == 0) begin
               $display("%t: unexpected result beat %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want != got) begin
                  for (int k = 0; k < 9; k++)
                     if (want.inv[k] != got.inv[k])
                        $display("%t: inv[%0d] expected %h actual %h", $time, k,
                                 want.inv[k], got.inv[k]);
                  if (want.det != got.det)
                     $display("%t: det expected %h actual %h", $time, want.det, got.det);
                  if (want.singular != got.singular)
                     $display("%t: singular expected %b actual %b", $time,
                              want.singular, got.singular);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [343:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   int           fail_count;
   int           pending;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           quiet_cycles;
   logic [143:0] matrix_q[$];

   matrix3x3_inverse dut (.*);

   m3i_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 1) ? 16'h0100 : 16'hff00);
         3: return 16'($signed($urandom_range(0, 32)) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [143:0] rand_matrix();
      logic [143:0] d;
      int mode;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) d[k*16 +: 16] = rand_elem();
      // mode 1 copies a column for a singular matrix; mode 0 copies one element only
      if (mode == 0) d[32 +: 16] = d[0 +: 16];
      if (mode == 1) d[96 +: 48] = d[0 +: 48];
      // nearly singular: second column one lsb off the first
      if (mode == 2) d[48 +: 48] = d[0 +: 48] ^ 48'h1;
      return d;
   endfunction

   // receiver stall, resampled every cycle
   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(1, 100) > recv_stall_pct);

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (matrix_q.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
            req_tvalid <= 1;
            req_tdata  <= matrix_q.pop_front();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("matrix3x3_inverse test failed");
         $finish;
      end
   end

   task automatic run_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int n = 0; n < count; n++) matrix_q.push_back(rand_matrix());
      while (matrix_q.size() > 0 || req_tvalid) @(posedge clock);
   endtask

   initial begin
      logic [143:0] d;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      // identity, zero, scaled identities, extreme elements
      d = '0;
      d[0 +: 16] = 16'h0100; d[64 +: 16] = 16'h0100; d[128 +: 16] = 16'h0100;
      matrix_q.push_back(d);
      matrix_q.push_back('0);
      matrix_q.push_back({9{16'h7fff}});
      matrix_q.push_back({9{16'h8000}});
      d = '0;
      d[0 +: 16] = 16'h8000; d[64 +: 16] = 16'h8000; d[128 +: 16] = 16'h8000;
      matrix_q.push_back(d);
      d[0 +: 16] = 16'h7fff; d[64 +: 16] = 16'h8000; d[128 +: 16] = 16'h7fff;
      matrix_q.push_back(d);
      // tiny determinant: large inverse elements that still fit the range
      d = '0;
      d[0 +: 16] = 16'h0001; d[64 +: 16] = 16'h0001; d[128 +: 16] = 16'h0001;
      matrix_q.push_back(d);
      d[64 +: 16] = 16'hffff;
      matrix_q.push_back(d);
      matrix_q.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                          16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      matrix_q.push_back({9{16'hffff}});
      matrix_q.push_back({16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0300,
                          16'h0000, 16'h0000, 16'h0000, 16'h0200});
      for (int n = 0; n < 6; n++)
         matrix_q.push_back({9{16'($urandom())}} ^ {144{1'b1}});
      run_phase(0, 0, 0);
      run_phase(0, 0, 300);
      run_phase(72, 0, 300);
      run_phase(0, 72, 300);
      run_phase(18, 18, 300);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (pending > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("matrix3x3_inverse test passed");
      else
         $display("matrix3x3_inverse test failed");
      $finish;
   end

endmodule
